// ===== rtl/u8u16_pkg.sv =====
// shared types and constants of the utf-8 to utf-16 transcoder
`default_nettype none

package u8u16_pkg;

  // replacement character and code point limits
  localparam logic [15:0] ReplUnit  = 16'hFFFD;
  localparam logic [20:0] MaxPoint  = 21'h10FFFF;
  localparam logic [19:0] PointBase = 20'h10000;
  localparam logic [15:0] SurrHigh  = 16'hD800;
  localparam logic [15:0] SurrLow   = 16'hDC00;

  // how many code units follow the replacement run of one descriptor
  localparam logic [1:0] TailNone = 2'd0;
  localparam logic [1:0] TailOne  = 2'd1;
  localparam logic [1:0] TailPair = 2'd2;

  // class of a byte standing as a lead
  typedef enum logic [2:0] {
    LeadAscii = 3'd0,
    LeadTwo   = 3'd1,
    LeadThree = 3'd2,
    LeadFour  = 3'd3,
    LeadBad   = 3'd4
  } lead_kind_e;

  // work for the back end: a run of replacement units, then zero to two units
  typedef struct packed {
    logic [2:0]  rep;
    logic [1:0]  tail;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        last;
  } u8u16_desc_t;

endpackage

`default_nettype wire

// ===== rtl/u8u16_front.sv =====
// front end: takes input bytes, tracks the pending sequence, builds descriptors
`default_nettype none

module u8u16_front import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        string_end_i,
  input  logic        q_ready_i,
  output logic        push_o,
  output u8u16_desc_t desc_o,
  output logic        seq_pending_o
);

  logic [1:0]  wanted_q, wanted_d;
  logic [1:0]  taken_q, taken_d;
  logic [20:0] partial_q, partial_d;

  lead_kind_e  lead_kind;
  logic        lead_rep;
  logic        lead_tail;
  logic [1:0]  lead_wanted;
  logic [20:0] lead_partial;

  logic        accept;
  logic        is_cont;
  logic [20:0] acc;
  logic [1:0]  taken_n;
  logic [19:0] supp;

  assign in_ready_o    = q_ready_i;
  assign accept        = in_valid_i && q_ready_i;
  assign seq_pending_o = (wanted_q != 2'd0);
  assign is_cont       = (in_byte_i[7:6] == 2'b10);
  assign acc           = {partial_q[14:0], in_byte_i[5:0]};
  assign taken_n       = taken_q + 2'd1;
  assign supp          = acc[19:0] - PointBase;

  // classify the byte as a lead
  always_comb begin
    case (in_byte_i) inside
      8'b0???????: lead_kind = LeadAscii;
      8'b110?????: lead_kind = LeadTwo;
      8'b1110????: lead_kind = LeadThree;
      8'b11110???: lead_kind = LeadFour;
      default:     lead_kind = LeadBad;
    endcase
  end

  // what the byte does when taken as a lead
  always_comb begin
    lead_rep     = 1'b0;
    lead_tail    = 1'b0;
    lead_wanted  = 2'd0;
    lead_partial = '0;
    case (lead_kind)
      LeadAscii: lead_tail = 1'b1;
      LeadTwo: begin
        lead_wanted  = 2'd1;
        lead_partial = {16'b0, in_byte_i[4:0]};
        lead_rep     = string_end_i;
      end
      LeadThree: begin
        lead_wanted  = 2'd2;
        lead_partial = {17'b0, in_byte_i[3:0]};
        lead_rep     = string_end_i;
      end
      LeadFour: begin
        lead_wanted  = 2'd3;
        lead_partial = {18'b0, in_byte_i[2:0]};
        lead_rep     = string_end_i;
      end
      default: lead_rep = 1'b1;
    endcase
  end

  // descriptor and next sequence state
  always_comb begin
    desc_o.rep   = 3'd0;
    desc_o.tail  = TailNone;
    desc_o.unit0 = {8'h00, in_byte_i};
    desc_o.unit1 = '0;
    desc_o.last  = string_end_i;
    wanted_d     = wanted_q;
    taken_d      = taken_q;
    partial_d    = partial_q;
    if (wanted_q == 2'd0) begin
      desc_o.rep  = {2'b00, lead_rep};
      desc_o.tail = {1'b0, lead_tail};
      wanted_d    = lead_wanted;
      taken_d     = 2'd0;
      partial_d   = lead_partial;
    end else if (is_cont) begin
      if (taken_n >= wanted_q) begin
        wanted_d  = 2'd0;
        taken_d   = 2'd0;
        partial_d = '0;
        if (acc[20:16] == 5'd0) begin
          desc_o.tail  = TailOne;
          desc_o.unit0 = acc[15:0];
        end else if (acc <= MaxPoint) begin
          desc_o.tail  = TailPair;
          desc_o.unit0 = SurrHigh | {6'b0, supp[19:10]};
          desc_o.unit1 = SurrLow | {6'b0, supp[9:0]};
        end else begin
          desc_o.rep = 3'd1;
        end
      end else if (string_end_i) begin
        desc_o.rep = 3'd1 + {1'b0, taken_n};
      end else begin
        taken_d   = taken_n;
        partial_d = acc;
      end
    end else begin
      // broken sequence: flush it, then the byte starts afresh
      desc_o.rep  = 3'd1 + {1'b0, taken_q} + {2'b00, lead_rep};
      desc_o.tail = {1'b0, lead_tail};
      wanted_d    = lead_wanted;
      taken_d     = 2'd0;
      partial_d   = lead_partial;
    end
    if (string_end_i) begin
      wanted_d  = 2'd0;
      taken_d   = 2'd0;
      partial_d = '0;
    end
  end

  assign push_o = accept && ((desc_o.rep != 3'd0) || (desc_o.tail != TailNone));

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q  <= 2'd0;
      taken_q   <= 2'd0;
      partial_q <= '0;
    end else if (accept) begin
      wanted_q  <= wanted_d;
      taken_q   <= taken_d;
      partial_q <= partial_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8u16_queue.sv =====
// short descriptor queue between front and back end
`default_nettype none

module u8u16_queue import u8u16_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  u8u16_desc_t push_data_i,
  output logic        not_full_o,
  output logic        head_valid_o,
  output u8u16_desc_t head_o,
  input  logic        pop_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  u8u16_desc_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign not_full_o   = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8u16_back.sv =====
// back end: expands descriptors to words, one per cycle unless output stalls
`default_nettype none

module u8u16_back import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  u8u16_desc_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        run_last_o,
  output logic        text_done_o
);

  logic [2:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [15:0] code_q, code_d;
  logic        run_last_q, run_last_d;
  logic        done_q, done_d;

  logic        load;
  logic [2:0]  total;
  logic        is_final;

  assign load     = head_valid_i && (!valid_q || out_ready_i);
  assign total    = head_i.rep + {1'b0, head_i.tail};
  assign is_final = (idx_q == total - 3'd1);
  assign pop_o    = load && is_final;

  // pick the unit at the current position of the head descriptor
  always_comb begin
    idx_d      = idx_q;
    valid_d    = valid_q;
    code_d     = code_q;
    run_last_d = run_last_q;
    done_d     = done_q;
    if (load) begin
      valid_d    = 1'b1;
      run_last_d = is_final;
      done_d     = is_final && head_i.last;
      idx_d      = is_final ? 3'd0 : idx_q + 3'd1;
      if (idx_q < head_i.rep) begin
        code_d = ReplUnit;
      end else if (idx_q == head_i.rep) begin
        code_d = head_i.unit0;
      end else begin
        code_d = head_i.unit1;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    run_last_q <= run_last_d;
    done_q     <= done_d;
  end

  assign out_valid_o = valid_q;
  assign code_unit_o = code_q;
  assign run_last_o  = run_last_q;
  assign text_done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// top level of the utf-8 to utf-16 transcoder
`default_nettype none

// Converts a UTF-8 byte stream, one byte per input word with string_end on
// the final byte, into UTF-16 code units. Bytes are taken one per cycle while
// the queue has room; a byte that completes a BMP character, or is ASCII,
// yields one word, a supplementary character yields a surrogate pair, and
// invalid or truncated sequences yield U+FFFD for each byte involved (up to
// four words for one byte), but a code point over U+10FFFF yields one U+FFFD.
// The front end decodes bytes and queues compact descriptors; the back end
// emits one code unit per cycle through a registered output unless stalled,
// so throughput is one byte per cycle while each byte yields at most one
// word; bytes yielding more hold the back end, buffered by a QueueDepth-entry
// queue. Overlong forms and surrogate code points are not checked.
module utf8_to_utf16_transcoder import u8u16_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        run_last_o,
  output logic        text_done_o
);

  logic        q_not_full;
  logic        push;
  u8u16_desc_t push_desc;
  logic        seq_pending;
  logic        head_valid;
  u8u16_desc_t head;
  logic        pop;

  // byte decode
  u8u16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .string_end_i (string_end_i),
    .q_ready_i    (q_not_full),
    .push_o       (push),
    .desc_o       (push_desc),
    .seq_pending_o(seq_pending)
  );

  // descriptor queue
  u8u16_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .not_full_o  (q_not_full),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  // code unit emission
  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_unit_o (code_unit_o),
    .run_last_o  (run_last_o),
    .text_done_o (text_done_o)
  );

`ifndef SYNTH
  // the final byte of a string always produces at least one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && string_end_i) |-> push)
    else $error("final byte produced no descriptor");

  // no sequence stays pending past the end of a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && string_end_i) |=> !seq_pending)
    else $error("sequence pending after string end");

  // the end of the text is also the end of its byte's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_done_o) |-> run_last_o)
    else $error("text_done without run_last");

  // a pop only happens on a loaded head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
